/* design/fbfl_pkg.sv */
// Shared types, constants and codes for the fixed-block free-list allocator.
package fbfl_pkg;

   // Field and register widths
   localparam int OFFSET_WIDTH    = 24;
   localparam int SIZE_WIDTH      = 16;
   localparam int COUNT_WIDTH     = 9;
   localparam int INDEX_WIDTH     = 8;
   localparam int LINK_WIDTH      = 8;
   localparam int PROD_WIDTH      = SIZE_WIDTH + COUNT_WIDTH;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 16;

   // Default pool depth
   localparam int MAX_BLOCKS_DEFAULT = 256;

   // Restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS       = OFFSET_WIDTH;
   localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS);

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_COUNT = 1'b1;

   // Register reset values
   localparam logic [SIZE_WIDTH-1:0]  BLOCK_SIZE_RESET  = 16'd1;
   localparam logic [COUNT_WIDTH-1:0] BLOCK_COUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_REINIT = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_EMPTY    = 3'd1,
      STATUS_RANGE    = 3'd2,
      STATUS_MISALIGN = 3'd3,
      STATUS_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_ALLOC_POP,
      STATE_FREE_CHECK,
      STATE_FREE_DIV,
      STATE_FREE_PUSH
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic [OFFSET_WIDTH-1:0] free_offset;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [OFFSET_WIDTH-1:0] block_offset;
      logic [INDEX_WIDTH-1:0]  block_index;
      logic [COUNT_WIDTH-1:0]  free_count;
   } rsp_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load_req;
      logic       mul_en;
      logic       mul_count;
      logic       ram_read;
      logic       div_start;
      logic       div_step;
      logic       pop;
      logic       push;
      logic       reinit;
      logic       emit;
      status_type emit_status;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic avail_zero;
      logic out_of_range;
      logic misaligned;
      logic pool_full;
      logic div_last;
   } dp_status_type;

endpackage

/* design/fbfl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fbfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/fbfl_ctrl.sv */
// Controller state machine that sequences allocate, free and reinitialise requests.
module fbfl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fbfl_pkg::op_type       op,
   input  fbfl_pkg::dp_status_type dp_status,
   output fbfl_pkg::dp_cmd_type   dp_cmd,
   output logic                   busy,
   output logic                   csr_ready
);

   fbfl_pkg::state_type state_ff;
   fbfl_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbfl_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      dp_cmd.emit_status = fbfl_pkg::STATUS_OK;

      case (state_ff)
         fbfl_pkg::STATE_IDLE: begin
            if (start) begin
               dp_cmd.load_req = 1'b1;
               case (op)
                  fbfl_pkg::OP_ALLOC: begin
                     if (dp_status.avail_zero) begin
                        dp_cmd.emit        = 1'b1;
                        dp_cmd.emit_status = fbfl_pkg::STATUS_EMPTY;
                     end else begin
                        // Read the head link and scale the head index together.
                        dp_cmd.ram_read = 1'b1;
                        dp_cmd.mul_en   = 1'b1;
                        state_in        = fbfl_pkg::STATE_ALLOC_POP;
                     end
                  end
                  fbfl_pkg::OP_FREE: begin
                     // Pool span in bytes for the range check.
                     dp_cmd.mul_en    = 1'b1;
                     dp_cmd.mul_count = 1'b1;
                     state_in         = fbfl_pkg::STATE_FREE_CHECK;
                  end
                  fbfl_pkg::OP_REINIT: begin
                     dp_cmd.reinit = 1'b1;
                     dp_cmd.emit   = 1'b1;
                  end
                  default: begin
                     dp_cmd.emit = 1'b1;
                  end
               endcase
            end
         end

         fbfl_pkg::STATE_ALLOC_POP: begin
            dp_cmd.pop  = 1'b1;
            dp_cmd.emit = 1'b1;
            state_in    = fbfl_pkg::STATE_IDLE;
         end

         fbfl_pkg::STATE_FREE_CHECK: begin
            if (dp_status.out_of_range) begin
               dp_cmd.emit        = 1'b1;
               dp_cmd.emit_status = fbfl_pkg::STATUS_RANGE;
               state_in           = fbfl_pkg::STATE_IDLE;
            end else begin
               dp_cmd.div_start = 1'b1;
               state_in         = fbfl_pkg::STATE_FREE_DIV;
            end
         end

         fbfl_pkg::STATE_FREE_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (dp_status.div_last) begin
               state_in = fbfl_pkg::STATE_FREE_PUSH;
            end
         end

         fbfl_pkg::STATE_FREE_PUSH: begin
            dp_cmd.emit = 1'b1;
            state_in    = fbfl_pkg::STATE_IDLE;
            if (dp_status.misaligned) begin
               dp_cmd.emit_status = fbfl_pkg::STATUS_MISALIGN;
            end else if (dp_status.pool_full) begin
               dp_cmd.emit_status = fbfl_pkg::STATUS_FULL;
            end else begin
               dp_cmd.push = 1'b1;
            end
         end

         default: begin
            state_in = fbfl_pkg::STATE_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != fbfl_pkg::STATE_IDLE);
   assign csr_ready = (state_ff == fbfl_pkg::STATE_IDLE);

endmodule

/* design/fbfl_dpath.sv */
// Datapath: configuration registers, free list, multiplier, divider and result register.
module fbfl_dpath #(
   parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fbfl_pkg::req_type                     req_data,
   input  logic                                  csr_write,
   input  logic [fbfl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [fbfl_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  fbfl_pkg::dp_cmd_type                  dp_cmd,
   output fbfl_pkg::dp_status_type               dp_status,
   output logic                                  rsp_valid,
   output fbfl_pkg::rsp_type                     rsp_data
);

   localparam int IDXW = $clog2(MAX_BLOCKS);
   localparam logic [fbfl_pkg::COUNT_WIDTH-1:0] MAX_COUNT =
      fbfl_pkg::COUNT_WIDTH'(MAX_BLOCKS);

   logic [fbfl_pkg::SIZE_WIDTH-1:0]   block_size_ff;
   logic [fbfl_pkg::COUNT_WIDTH-1:0]  block_count_ff;
   logic [fbfl_pkg::SIZE_WIDTH-1:0]   eff_size;
   logic [fbfl_pkg::COUNT_WIDTH-1:0]  eff_count;

   logic [fbfl_pkg::OFFSET_WIDTH-1:0] offset_ff;
   logic [fbfl_pkg::LINK_WIDTH-1:0]   head_ff, head_in;
   logic [fbfl_pkg::COUNT_WIDTH-1:0]  avail_ff, avail_in;
   logic [MAX_BLOCKS-1:0]             valid_ff, valid_in;

   logic [fbfl_pkg::COUNT_WIDTH-1:0]  mul_b;
   logic [fbfl_pkg::PROD_WIDTH-1:0]   prod_ff;

   logic [fbfl_pkg::SIZE_WIDTH-1:0]      div_rem_ff, div_rem_in;
   logic [fbfl_pkg::OFFSET_WIDTH-1:0]    div_quo_ff, div_quo_in;
   logic [fbfl_pkg::DIV_COUNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic [fbfl_pkg::SIZE_WIDTH:0]        rem_shift;
   logic [fbfl_pkg::SIZE_WIDTH:0]        rem_diff;
   logic                                 quo_bit;

   logic [IDXW-1:0]                  head_idx;
   logic [IDXW-1:0]                  push_idx;
   logic [fbfl_pkg::LINK_WIDTH-1:0]  ram_rdata;
   logic [fbfl_pkg::LINK_WIDTH-1:0]  link_val;

   logic                             rsp_valid_ff;
   fbfl_pkg::rsp_type                rsp_ff, rsp_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= fbfl_pkg::BLOCK_SIZE_RESET;
         block_count_ff <= fbfl_pkg::BLOCK_COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            fbfl_pkg::CSR_BLOCK_SIZE: begin
               block_size_ff <= csr_wdata;
            end
            fbfl_pkg::CSR_BLOCK_COUNT: begin
               block_count_ff <= csr_wdata[fbfl_pkg::COUNT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A zero block size acts as one; the count is clipped to the pool depth.
   assign eff_size  = (block_size_ff == '0) ? fbfl_pkg::SIZE_WIDTH'(1) : block_size_ff;
   assign eff_count = (block_count_ff > MAX_COUNT) ? MAX_COUNT : block_count_ff;

   // Request offset capture.
   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         offset_ff <= req_data.free_offset;
      end
   end

   // Shared multiplier: head index for allocate, block count for the range check.
   assign mul_b = dp_cmd.mul_count ? eff_count : {1'b0, head_ff};

   always_ff @(posedge clock) begin
      if (dp_cmd.mul_en) begin
         prod_ff <= {{fbfl_pkg::COUNT_WIDTH{1'b0}}, eff_size}
                  * {{fbfl_pkg::SIZE_WIDTH{1'b0}}, mul_b};
      end
   end

   // Restoring divider step: offset divided by the block size.
   assign rem_shift = {div_rem_ff, div_quo_ff[fbfl_pkg::OFFSET_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, eff_size};
   assign quo_bit   = (rem_shift >= {1'b0, eff_size});

   always_comb begin
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      if (dp_cmd.div_start) begin
         div_rem_in = '0;
         div_quo_in = offset_ff;
         div_cnt_in = '0;
      end else if (dp_cmd.div_step) begin
         div_rem_in = quo_bit ? rem_diff[fbfl_pkg::SIZE_WIDTH-1:0]
                              : rem_shift[fbfl_pkg::SIZE_WIDTH-1:0];
         div_quo_in = {div_quo_ff[fbfl_pkg::OFFSET_WIDTH-2:0], quo_bit};
         div_cnt_in = div_cnt_ff + fbfl_pkg::DIV_COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_cnt_ff <= div_cnt_in;
   end

   // Link store; an entry that has not been written since reinitialise links to the next.
   assign head_idx = head_ff[IDXW-1:0];
   assign push_idx = div_quo_ff[IDXW-1:0];

   fbfl_ram #(
      .WIDTH (fbfl_pkg::LINK_WIDTH),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.push),
      .wr_addr (push_idx),
      .wr_data (head_ff),
      .rd_en   (dp_cmd.ram_read),
      .rd_addr (head_idx),
      .rd_data (ram_rdata)
   );

   assign link_val = valid_ff[head_idx] ? ram_rdata
                                        : head_ff + fbfl_pkg::LINK_WIDTH'(1);

   // Free-list head, free count and written-entry flags.
   always_comb begin
      head_in  = head_ff;
      avail_in = avail_ff;
      valid_in = valid_ff;
      if (dp_cmd.reinit) begin
         head_in  = '0;
         avail_in = eff_count;
         valid_in = '0;
      end else if (dp_cmd.pop) begin
         head_in  = link_val;
         avail_in = avail_ff - fbfl_pkg::COUNT_WIDTH'(1);
      end else if (dp_cmd.push) begin
         head_in  = div_quo_ff[fbfl_pkg::LINK_WIDTH-1:0];
         avail_in = avail_ff + fbfl_pkg::COUNT_WIDTH'(1);
         valid_in[push_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         avail_ff <= MAX_COUNT;
         valid_ff <= '0;
      end else begin
         head_ff  <= head_in;
         avail_ff <= avail_in;
         valid_ff <= valid_in;
      end
   end

   // Status back to the controller.
   assign dp_status.avail_zero   = (avail_ff == '0);
   assign dp_status.out_of_range = ({1'b0, offset_ff} >= prod_ff);
   assign dp_status.misaligned   = (div_rem_ff != '0);
   assign dp_status.pool_full    = (avail_ff >= eff_count);
   assign dp_status.div_last     =
      (div_cnt_ff == fbfl_pkg::DIV_COUNT_WIDTH'(fbfl_pkg::DIV_STEPS - 1));

   // Result register; failed operations report zero offset and index.
   always_comb begin
      rsp_in              = rsp_ff;
      if (dp_cmd.emit) begin
         rsp_in.status       = dp_cmd.emit_status;
         rsp_in.block_offset = '0;
         rsp_in.block_index  = '0;
         rsp_in.free_count   = avail_in;
         if (dp_cmd.pop) begin
            rsp_in.block_offset = prod_ff[fbfl_pkg::OFFSET_WIDTH-1:0];
            rsp_in.block_index  = head_ff;
         end else if (dp_cmd.push) begin
            rsp_in.block_index  = div_quo_ff[fbfl_pkg::INDEX_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/fixed_block_free_list_allocator.sv */
// Top level of the fixed-block free-list allocator.
// Allocate reads the head link, then pops; free runs the range check and, in range,
// the 24-step restoring divider and the push; reinitialise, empty-pool allocate and
// the unused code finish in the request's own cycle; one request is in flight at a
// time, the result strobe comes in the cycle after completion. The receiver cannot stall.
// Synchronous reset relinks the pool at once: head 0, all blocks free, size 1.
module fixed_block_free_list_allocator #(
   parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  fbfl_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output fbfl_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fbfl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fbfl_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   fbfl_pkg::dp_cmd_type    dp_cmd;
   fbfl_pkg::dp_status_type dp_status;
   logic                    csr_write;

   // Register writes complete on the valid and ready handshake.
   assign csr_write = csr_valid & csr_ready;

   fbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_data.op),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy),
      .csr_ready (csr_ready)
   );

   fbfl_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
